@@ sv/bgu_pkg.sv @@
// shared types and constants for the background unmix block
`timescale 1ns / 1ps

package bgu_pkg;

	// channel width and full-scale value
	localparam int CB   = 8;
	localparam int CMAX = (1 << CB) - 1;

	// remainder width, divisor width (twice the denominator), quotient width
	localparam int RW = 2 * CB + 2;
	localparam int DW = CB + 1;
	localparam int QW = CB + 1;

	// one divider cell per quotient bit, including the saturation bit
	localparam int NCELLS = QW;
	localparam int LANES  = 4;

	// start to done, in clock cycles
	localparam int LATENCY = NCELLS + 3;

	// register map
	localparam logic [0:0] REG_HAS_ALPHA = 1'b0;

	typedef logic [CB-1:0] chan_t;

	typedef struct packed {
		chan_t comp_red;
		chan_t comp_green;
		chan_t comp_blue;
		chan_t comp_alpha;
		chan_t fg_red;
		chan_t fg_green;
		chan_t fg_blue;
		chan_t fg_alpha;
	} pix_t;

	typedef struct packed {
		chan_t bg_red;
		chan_t bg_green;
		chan_t bg_blue;
		chan_t bg_alpha;
	} bg_t;

	// one division lane: partial remainder and quotient bits found so far
	typedef struct packed {
		logic [RW-1:0] r;
		logic [QW-1:0] q;
	} lane_t;

	// word handed from cell to cell
	typedef struct packed {
		logic                   valid;
		logic                   opaque;
		logic [LANES-1:0]       neg;
		lane_t [LANES-1:0]      lane;
		logic [DW-1:0]          d;
		chan_t [2:0]            comp;
	} stage_t;

endpackage

@@ sv/bgu_front.sv @@
// front end: foreground products, numerators and rounding offset
`timescale 1ns / 1ps

module bgu_front import bgu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   has_alpha,
	input  pix_t   pix,
	output stage_t dout
);

	localparam int AW = RW + 1;

	logic              valid_s1;
	chan_t             c_s1 [3];
	chan_t             ca_s1;
	chan_t             fa_s1;
	logic [2*CB-1:0]   prod_s1 [3];
	stage_t            stage_s2;

	logic signed [RW-1:0] num [LANES];
	logic signed [AW-1:0] afull [LANES];
	logic signed [CB:0]   diff;
	logic signed [RW-1:0] dx;
	logic signed [AW-1:0] den_ext;
	chan_t                den;
	stage_t               nxt;

	// stage 1: capture the word and form fa*f per colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		c_s1[0]    <= pix.comp_red;
		c_s1[1]    <= pix.comp_green;
		c_s1[2]    <= pix.comp_blue;
		ca_s1      <= has_alpha ? pix.comp_alpha : chan_t'(CMAX);
		fa_s1      <= pix.fg_alpha;
		prod_s1[0] <= (2*CB)'(pix.fg_alpha) * (2*CB)'(pix.fg_red);
		prod_s1[1] <= (2*CB)'(pix.fg_alpha) * (2*CB)'(pix.fg_green);
		prod_s1[2] <= (2*CB)'(pix.fg_alpha) * (2*CB)'(pix.fg_blue);
	end

	// stage 2: numerators, then 2*num + den for round to nearest
	always_comb begin
		den     = chan_t'(CMAX) - fa_s1;
		den_ext = $signed({{(AW-CB){1'b0}}, den});
		for (int i = 0; i < 3; i++) begin
			num[i] = $signed({2'b00, c_s1[i], {CB{1'b0}}})
				- $signed({{(RW-CB){1'b0}}, c_s1[i]})
				- $signed({2'b00, prod_s1[i]});
		end
		diff   = $signed({1'b0, ca_s1}) - $signed({1'b0, fa_s1});
		dx     = RW'(diff);
		num[3] = (dx <<< CB) - dx;

		nxt        = '0;
		nxt.valid  = valid_s1;
		nxt.opaque = (fa_s1 == chan_t'(CMAX));
		nxt.d      = {den, 1'b0};
		for (int i = 0; i < 3; i++) begin
			nxt.comp[i] = c_s1[i];
		end
		for (int l = 0; l < LANES; l++) begin
			afull[l]       = (AW'(num[l]) <<< 1) + den_ext;
			nxt.neg[l]     = num[l][RW-1];
			nxt.lane[l].r  = afull[l][RW-1:0];
			nxt.lane[l].q  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
		end else begin
			stage_s2 <= nxt;
		end
	end

	assign dout = stage_s2;

endmodule

@@ sv/bgu_cell.sv @@
// one restoring divider cell: settles one quotient bit on all four lanes
`timescale 1ns / 1ps

module bgu_cell import bgu_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t din,
	output stage_t dout
);

	logic [RW-1:0] dsh;
	stage_t        nxt;
	stage_t        stage_s1;

	// trial subtract of the shifted divisor
	always_comb begin
		nxt = din;
		dsh = RW'(din.d) << SHIFT;
		for (int l = 0; l < LANES; l++) begin
			if (din.lane[l].r >= dsh) begin
				nxt.lane[l].r        = din.lane[l].r - dsh;
				nxt.lane[l].q[SHIFT] = 1'b1;
			end
		end
	end

	// hand the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			stage_s1 <= nxt;
		end
	end

	assign dout = stage_s1;

endmodule

@@ sv/background_unmix_from_composite.sv @@
// Recovers the background pixel from a composite and a known foreground by undoing the
// over operator, one pixel per clock. A word is taken whenever start is high; busy is
// always low. Each result appears on bg for one cycle with done high, registered in turn
// by the two front stages, the chain of CB + 1 divider cells (one quotient bit each, the
// top bit flags saturation) and the output register. The results cannot be stalled by
// the receiver.
`timescale 1ns / 1ps

module background_unmix_from_composite import bgu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pix_t        pix,
	output logic        done,
	output bg_t         bg,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic   has_alpha_q;
	stage_t chain [NCELLS+1];
	stage_t last;
	chan_t  res [LANES];
	bg_t    out_s1;
	logic   done_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_alpha_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr[2] == REG_HAS_ALPHA)) begin
			has_alpha_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HAS_ALPHA) ? {31'b0, has_alpha_q} : 32'b0;
	assign busy   = 1'b0;

	// numerators and divisor
	bgu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.has_alpha (has_alpha_q),
		.pix       (pix),
		.dout      (chain[0])
	);

	// divider chain, saturation bit first
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		bgu_cell #(
			.SHIFT (CB - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	assign last = chain[NCELLS];

	// clamp and opaque override
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (last.opaque) begin
				res[l] = (l < 3) ? last.comp[l % 3] : '0;
			end else if (last.neg[l]) begin
				res[l] = '0;
			end else if (last.lane[l].q[CB]) begin
				res[l] = chan_t'(CMAX);
			end else begin
				res[l] = last.lane[l].q[CB-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		out_s1.bg_red   <= res[0];
		out_s1.bg_green <= res[1];
		out_s1.bg_blue  <= res[2];
		out_s1.bg_alpha <= res[3];
	end

	assign done = done_q;
	assign bg   = out_s1;

	// every word comes out after a fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LATENCY) done)
		else $error("result missing after start");

	// no result without a word taken
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without matching start");

	// unsaturated lanes finish with a remainder below the divisor
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(last.valid && !last.opaque) |->
		((last.neg[0] || last.lane[0].q[CB] || (last.lane[0].r < RW'(last.d))) &&
		 (last.neg[1] || last.lane[1].q[CB] || (last.lane[1].r < RW'(last.d))) &&
		 (last.neg[2] || last.lane[2].q[CB] || (last.lane[2].r < RW'(last.d))) &&
		 (last.neg[3] || last.lane[3].q[CB] || (last.lane[3].r < RW'(last.d)))))
		else $error("divider remainder not reduced");

endmodule
